// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the RTL of the PEC15 frame builder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Antecedent implies consequent in the same cycle.
`define ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);
// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_SAME(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/pcfb_pkg.sv =====
// Package with constants, types and state codes of the PEC15 frame builder.
`default_nettype none
package pcfb_pkg;

  localparam int BYTE_W       = 8;
  localparam int PEC_W        = 15;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 3;
  localparam int CNT_W        = 3;
  localparam int BIT_CNT_W    = 4;
  localparam int MAX_DATA_BYTES = 6;

  localparam logic [CNT_W-1:0]      MAX_DEVICES_C    = 3'd7;
  localparam logic [CNT_W-1:0]      MAX_DATA_BYTES_C = 3'd6;
  localparam logic [PEC_W-1:0]      PEC_POLY         = 15'h4599;
  localparam logic [PEC_W-1:0]      PEC_SEED         = 15'd16;
  localparam logic [BYTE_W-1:0]     CMD_BAD_MASK     = 8'hF8;
  localparam logic [CNT_W-1:0]      CHAIN_LEN_RST    = 3'd1;
  localparam logic [CNT_W-1:0]      DATA_LENGTH_RST  = 3'd6;
  localparam logic [CNT_W-1:0]      CMD_BYTES        = 3'd2;
  localparam logic [BIT_CNT_W-1:0]  BITS_PER_BYTE    = 4'd8;

  localparam logic [CFG_IDX_W-1:0] REG_CHAIN_LEN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_LENGTH = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR,
    ST_CMD_CRC,
    ST_CMD_EMIT,
    ST_DATA_CRC,
    ST_DATA_EMIT
  } state_t;

  typedef struct packed {
    logic              init;
    logic              load;
    logic [BYTE_W-1:0] data;
  } crc_ctrl_t;

  typedef struct packed {
    logic                busy;
    logic [2*BYTE_W-1:0] pec;
  } crc_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/pcfb_if.sv =====
// Handshake interfaces for the command input and the frame byte output.
`default_nettype none
interface pcfb_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] command_high;
  logic [7:0] command_low;
  logic [7:0] data_byte_0;
  logic [7:0] data_byte_1;
  logic [7:0] data_byte_2;
  logic [7:0] data_byte_3;
  logic [7:0] data_byte_4;
  logic [7:0] data_byte_5;

  modport source (
    output valid, operation, command_high, command_low,
           data_byte_0, data_byte_1, data_byte_2, data_byte_3, data_byte_4, data_byte_5,
    input  ready
  );
  modport sink (
    input  valid, operation, command_high, command_low,
           data_byte_0, data_byte_1, data_byte_2, data_byte_3, data_byte_4, data_byte_5,
    output ready
  );
endinterface

interface pcfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_last;
  logic       frame_error;

  modport source (output valid, frame_byte, frame_last, frame_error, input ready);
  modport sink   (input valid, frame_byte, frame_last, frame_error, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/pec15_command_frame_builder.sv =====
// Top level: PEC15 command frame builder for daisy-chained battery monitors.
//
// Input channel in_chan takes one command (operation, two command bytes, six data
// bytes); output channel out_chan gives one frame byte per transfer with a last
// flag and an error flag. Configuration: cfg_we writes register cfg_index
// (0 = device count, 1 = data_length) with cfg_wdata; other indexes are ignored.
// The PEC15 is computed one bit per cycle in a serial CRC unit, one byte at a
// time. A command_high byte with any of bits 7..3 set gives a single error
// byte from the error state. One item is in work at a time: in_chan.ready is
// high only while the sequencer is idle. A one-entry output register holds each
// byte until the receiver takes it; a stall simply pauses the sequence.
// Synchronous reset clears the sequencer and output valid and sets the
// device count to 1 and data_length to 6.
`default_nettype none
`include "assert_macros.svh"
module pec15_command_frame_builder
  import pcfb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  pcfb_in_if.sink               in_chan,
  pcfb_out_if.source            out_chan
);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  dev_r, dev_nxt;
  logic [CNT_W-1:0]  chain_len_r, data_length_r;
  logic [CNT_W-1:0]  devs, len;

  logic              op_r;
  logic [BYTE_W-1:0] ch_r, cl_r;
  logic [BYTE_W-1:0] data_r [MAX_DATA_BYTES];
  logic [BYTE_W-1:0] data_sel;

  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_last_r, out_err_r;

  logic              in_xfer, slot_free;
  logic              emit, emit_last, emit_err;
  logic [BYTE_W-1:0] emit_byte;

  crc_ctrl_t         crc_ctrl;
  crc_stat_t         crc_stat;

  pcfb_crc u_crc (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (crc_ctrl),
    .stat  (crc_stat)
  );

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_xfer       = in_chan.valid && in_chan.ready;
  assign slot_free     = !out_valid_r || out_chan.ready;

  // Clamp configuration into the legal range.
  assign devs = (chain_len_r == '0) ? 3'd1 :
                (chain_len_r > MAX_DEVICES_C) ? MAX_DEVICES_C : chain_len_r;
  assign len  = (data_length_r > MAX_DATA_BYTES_C) ? MAX_DATA_BYTES_C : data_length_r;

  assign data_sel = (idx_r < MAX_DATA_BYTES_C) ? data_r[idx_r] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_len_r   <= CHAIN_LEN_RST;
      data_length_r <= DATA_LENGTH_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_CHAIN_LEN) begin
        chain_len_r <= cfg_wdata;
      end else if (cfg_index == REG_DATA_LENGTH) begin
        data_length_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r      <= in_chan.operation;
      ch_r      <= in_chan.command_high;
      cl_r      <= in_chan.command_low;
      data_r[0] <= in_chan.data_byte_0;
      data_r[1] <= in_chan.data_byte_1;
      data_r[2] <= in_chan.data_byte_2;
      data_r[3] <= in_chan.data_byte_3;
      data_r[4] <= in_chan.data_byte_4;
      data_r[5] <= in_chan.data_byte_5;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    dev_nxt       = dev_r;
    crc_ctrl      = '0;
    emit          = 1'b0;
    emit_byte     = '0;
    emit_last     = 1'b0;
    emit_err      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          idx_nxt = '0;
          if ((in_chan.command_high & CMD_BAD_MASK) != '0) begin
            state_nxt = ST_ERR;
          end else begin
            state_nxt     = ST_CMD_CRC;
            crc_ctrl.init = 1'b1;
          end
        end
      end
      ST_ERR: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          emit_err  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_CMD_CRC: begin
        if (!crc_stat.busy) begin
          if (idx_r == CMD_BYTES) begin
            state_nxt = ST_CMD_EMIT;
            idx_nxt   = '0;
          end else begin
            crc_ctrl.load = 1'b1;
            crc_ctrl.data = (idx_r == '0) ? ch_r : cl_r;
            idx_nxt       = idx_r + 1'b1;
          end
        end
      end
      ST_CMD_EMIT: begin
        if (slot_free) begin
          emit = 1'b1;
          unique case (idx_r[1:0])
            2'd0:    emit_byte = ch_r;
            2'd1:    emit_byte = cl_r;
            2'd2:    emit_byte = crc_stat.pec[2*BYTE_W-1:BYTE_W];
            default: emit_byte = crc_stat.pec[BYTE_W-1:0];
          endcase
          if (idx_r[1:0] == 2'd3) begin
            emit_last = !op_r;
            idx_nxt   = '0;
            if (op_r) begin
              state_nxt     = ST_DATA_CRC;
              crc_ctrl.init = 1'b1;
            end else begin
              state_nxt = ST_IDLE;
            end
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      ST_DATA_CRC: begin
        if (!crc_stat.busy) begin
          if (idx_r == len) begin
            state_nxt = ST_DATA_EMIT;
            idx_nxt   = '0;
            dev_nxt   = '0;
          end else begin
            crc_ctrl.load = 1'b1;
            crc_ctrl.data = data_sel;
            idx_nxt       = idx_r + 1'b1;
          end
        end
      end
      ST_DATA_EMIT: begin
        if (slot_free) begin
          emit = 1'b1;
          priority if (idx_r < len) begin
            emit_byte = data_sel;
            idx_nxt   = idx_r + 1'b1;
          end else if (idx_r == len) begin
            emit_byte = crc_stat.pec[2*BYTE_W-1:BYTE_W];
            idx_nxt   = idx_r + 1'b1;
          end else begin
            emit_byte = crc_stat.pec[BYTE_W-1:0];
            idx_nxt   = '0;
            // Close the frame after the last device copy.
            if (dev_r == devs - 1'b1) begin
              emit_last = 1'b1;
              state_nxt = ST_IDLE;
            end else begin
              dev_nxt = dev_r + 1'b1;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      dev_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      dev_r   <= dev_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= emit_byte;
      out_last_r <= emit_last;
      out_err_r  <= emit_err;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.frame_byte  = out_byte_r;
  assign out_chan.frame_last  = out_last_r;
  assign out_chan.frame_error = out_err_r;

  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_xfer, state_r != ST_IDLE, "idle after accept")
  `ASSERT_SAME(a_err_format, clk, rst_n, out_valid_r && out_err_r, out_last_r && (out_byte_r == '0), "bad error result")
  `ASSERT_SAME(a_crc_done_on_emit, clk, rst_n, state_r == ST_CMD_EMIT || state_r == ST_DATA_EMIT, !crc_stat.busy, "PEC still running while emitting")
  `ASSERT_NEXT(a_last_ends_frame, clk, rst_n, emit && emit_last, state_r == ST_IDLE, "frame continues after last byte")

endmodule
`default_nettype wire

// ===== hw/rtl/pcfb_crc.sv =====
// Bit-serial PEC15 engine: one message bit per cycle.
`default_nettype none
module pcfb_crc
  import pcfb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  crc_ctrl_t ctrl,
  output crc_stat_t stat
);

  logic [BYTE_W-1:0]    shift_r, shift_nxt;
  logic [BIT_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PEC_W-1:0]     rem_r, rem_nxt;
  logic                 busy;
  logic                 fb;
  logic [PEC_W-1:0]     step;

  assign busy = (cnt_r != '0);
  assign fb   = rem_r[PEC_W-1] ^ shift_r[BYTE_W-1];
  assign step = {rem_r[PEC_W-2:0], 1'b0} ^ (fb ? PEC_POLY : '0);

  always_comb begin
    cnt_nxt   = cnt_r;
    shift_nxt = shift_r;
    rem_nxt   = rem_r;
    if (ctrl.init) begin
      rem_nxt = PEC_SEED;
    end else if (busy) begin
      rem_nxt = step;
    end
    if (ctrl.load) begin
      cnt_nxt   = BITS_PER_BYTE;
      shift_nxt = ctrl.data;
    end else if (busy) begin
      cnt_nxt   = cnt_r - 1'b1;
      shift_nxt = {shift_r[BYTE_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    rem_r   <= rem_nxt;
  end

  assign stat.busy = busy;
  assign stat.pec  = {rem_r, 1'b0};

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for the PEC15 command frame builder: directed and random frames.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pcfb_pkg::*;

  localparam int CLK_HALF       = 10;
  localparam int RESET_CYCLES   = 5;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES  = 8;
  localparam int END_CYCLES     = 40;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 45;
  localparam int MAX_REPORTS    = 40;

  localparam logic OP_COMMAND = 1'b0;
  localparam logic OP_WRITE   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic             operation;
    logic [7:0]       command_high;
    logic [7:0]       command_low;
    logic [5:0][7:0]  data;
  } cmd_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_last;
    logic       frame_error;
  } frame_result_t;

  class frame_scoreboard;
    logic [CNT_W-1:0] chain_len;
    logic [CNT_W-1:0] data_length;
    frame_result_t    frame_q[$];
    int               fail_count;

    function new();
      chain_len   = CHAIN_LEN_RST;
      data_length = DATA_LENGTH_RST;
      fail_count  = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_CHAIN_LEN) begin
        chain_len = val;
      end else if (idx == REG_DATA_LENGTH) begin
        data_length = val;
      end
    endfunction

    // Shift one byte into the CRC-15 remainder, MSB first.
    function logic [PEC_W-1:0] pec_add(logic [PEC_W-1:0] rem, logic [7:0] b);
      logic [PEC_W-1:0] r;
      r = rem ^ {b, 7'b0};
      for (int k = 0; k < 8; k++) begin
        if (r[PEC_W-1]) r = (r << 1) ^ PEC_POLY;
        else r = r << 1;
      end
      return r;
    endfunction

    function void push(logic [7:0] b, logic last, logic err);
      frame_result_t e;
      e.frame_byte  = b;
      e.frame_last  = last;
      e.frame_error = err;
      frame_q.push_back(e);
    endfunction

    function void note_command(cmd_item_t c);
      logic [PEC_W-1:0] rem;
      logic [15:0]      word;
      int               devs;
      int               len;
      if ((c.command_high & CMD_BAD_MASK) != 0) begin
        push(8'h00, 1'b1, 1'b1);
        return;
      end
      devs = (chain_len == 0) ? 1 :
             (chain_len > MAX_DEVICES_C) ? int'(MAX_DEVICES_C) : int'(chain_len);
      len  = (data_length > MAX_DATA_BYTES_C) ? int'(MAX_DATA_BYTES_C) : int'(data_length);
      rem  = pec_add(pec_add(PEC_SEED, c.command_high), c.command_low);
      word = {rem, 1'b0};
      push(c.command_high, 1'b0, 1'b0);
      push(c.command_low, 1'b0, 1'b0);
      push(word[15:8], 1'b0, 1'b0);
      push(word[7:0], c.operation == OP_COMMAND, 1'b0);
      if (c.operation == OP_COMMAND) return;
      rem = PEC_SEED;
      for (int i = 0; i < len; i++) rem = pec_add(rem, c.data[i]);
      word = {rem, 1'b0};
      for (int d = 0; d < devs; d++) begin
        for (int i = 0; i < len; i++) push(c.data[i], 1'b0, 1'b0);
        push(word[15:8], 1'b0, 1'b0);
        push(word[7:0], d == devs - 1, 1'b0);
      end
    endfunction

    function void check_byte(frame_result_t got);
      frame_result_t want;
      if (frame_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: unexpected frame byte: expected none, actual byte %02h last %0b err %0b",
                   $time, got.frame_byte, got.frame_last, got.frame_error);
        return;
      end
      want = frame_q.pop_front();
      if (got.frame_byte !== want.frame_byte) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: frame_byte mismatch: expected %02h actual %02h",
                   $time, want.frame_byte, got.frame_byte);
      end
      if (got.frame_last !== want.frame_last) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: frame_last mismatch: expected %0b actual %0b",
                   $time, want.frame_last, got.frame_last);
      end
      if (got.frame_error !== want.frame_error) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: frame_error mismatch: expected %0b actual %0b",
                   $time, want.frame_error, got.frame_error);
      end
    endfunction

    function int pending();
      return frame_q.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  pcfb_in_if  in_ch();
  pcfb_out_if out_ch();

  pec15_command_frame_builder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_ch.sink),
    .out_chan  (out_ch.source)
  );

  frame_scoreboard sb;
  bit              tx_idle;
  bit              rx_stalls;
  bit              rx_hold_req;
  int              quiet_cycles;

  always #CLK_HALF clk = ~clk;

  // Mostly short idle stretches, now and then a long one.
  function automatic int idle_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
    return $urandom_range(1, 3);
  endfunction

  // Sample both channels and the config port at the rising edge.
  always @(posedge clk) begin
    cmd_item_t     c;
    frame_result_t r;
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else begin
      if (cfg_we) sb.write_register(cfg_index, cfg_wdata);
      if (in_ch.valid && in_ch.ready) begin
        c.operation    = in_ch.operation;
        c.command_high = in_ch.command_high;
        c.command_low  = in_ch.command_low;
        c.data         = {in_ch.data_byte_5, in_ch.data_byte_4, in_ch.data_byte_3,
                          in_ch.data_byte_2, in_ch.data_byte_1, in_ch.data_byte_0};
        sb.note_command(c);
      end
      if (out_ch.valid && out_ch.ready) begin
        r.frame_byte  = out_ch.frame_byte;
        r.frame_last  = out_ch.frame_last;
        r.frame_error = out_ch.frame_error;
        sb.check_byte(r);
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired with %0d frame bytes outstanding", $time, sb.pending());
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Frame byte receiver: random stalls plus one long hold-off on request.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
        out_ch.ready <= 1'b1;
      end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat (idle_len()) @(negedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic cmd_item_t make_command(logic op, logic [7:0] ch, logic [7:0] cl,
                                             logic [47:0] data);
    cmd_item_t c;
    c.operation    = op;
    c.command_high = ch;
    c.command_low  = cl;
    c.data         = data;
    return c;
  endfunction

  function automatic cmd_item_t random_command();
    cmd_item_t c;
    c.operation    = ($urandom_range(0, 9) < 7) ? OP_WRITE : OP_COMMAND;
    // Mostly legal command bytes, some with the reserved upper bits set.
    c.command_high = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(8, 255))
                                                 : 8'($urandom_range(0, 7));
    c.command_low  = 8'($urandom);
    c.data         = {16'($urandom), 32'($urandom)};
    return c;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_command(input cmd_item_t c, input int gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.operation    <= c.operation;
    in_ch.command_high <= c.command_high;
    in_ch.command_low  <= c.command_low;
    in_ch.data_byte_0  <= c.data[0];
    in_ch.data_byte_1  <= c.data[1];
    in_ch.data_byte_2  <= c.data[2];
    in_ch.data_byte_3  <= c.data[3];
    in_ch.data_byte_4  <= c.data[4];
    in_ch.data_byte_5  <= c.data[5];
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Drop valid and hold until every expected frame byte has been taken.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_command(random_command(),
                   (tx_idle && $urandom_range(0, 2) == 0) ? idle_len() : 0);
      // Pause the sender now and then until the frame drains.
      if ($urandom_range(0, 29) == 0) wait_drained();
    end
  endtask

  logic [CNT_W-1:0] phase_devs [RANDOM_PHASES] = '{3'd7, 3'd1, 3'd4, 3'd0, 3'd2, 3'd7, 3'd5, 3'd3};
  logic [CNT_W-1:0] phase_len  [RANDOM_PHASES] = '{3'd6, 3'd0, 3'd3, 3'd7, 3'd6, 3'd1, 3'd2, 3'd5};

  initial begin
    sb                 = new();
    clk                = 1'b0;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = REG_CHAIN_LEN;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.operation    = OP_COMMAND;
    in_ch.command_high = '0;
    in_ch.command_low  = '0;
    in_ch.data_byte_0  = '0;
    in_ch.data_byte_1  = '0;
    in_ch.data_byte_2  = '0;
    in_ch.data_byte_3  = '0;
    in_ch.data_byte_4  = '0;
    in_ch.data_byte_5  = '0;
    tx_idle            = 1'b0;
    rx_stalls          = 1'b0;
    rx_hold_req        = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset config, field extremes, rejected commands.
    send_command(make_command(OP_COMMAND, 8'h00, 8'h00, 48'h0), 0);
    send_command(make_command(OP_COMMAND, 8'h07, 8'hFF, 48'h0), 0);
    send_command(make_command(OP_WRITE, 8'h02, 8'h24, {6{8'hFF}}), 0);
    send_command(make_command(OP_WRITE, 8'h00, 8'h01, 48'h0), 0);
    send_command(make_command(OP_WRITE, 8'h05, 8'hA5, 48'h0123456789AB), 1);
    send_command(make_command(OP_COMMAND, 8'hF8, 8'h11, 48'h0), 0);
    send_command(make_command(OP_WRITE, 8'h08, 8'h22, {6{8'hFF}}), 0);
    send_command(make_command(OP_WRITE, 8'hFF, 8'hFF, {6{8'hFF}}), 0);
    send_command(make_command(OP_COMMAND, 8'h80, 8'h00, 48'h0), 0);
    wait_drained();

    // Most devices, empty data: every copy carries only the empty-message PEC.
    write_register(REG_CHAIN_LEN, 3'd7);
    write_register(REG_DATA_LENGTH, 3'd0);
    send_command(make_command(OP_WRITE, 8'h01, 8'h60, 48'hFFFFFFFFFFFF), 0);
    send_command(make_command(OP_COMMAND, 8'h03, 8'h3C, 48'h0), 0);
    wait_drained();

    // Device count of zero acts as one; length seven clamps to six.
    write_register(REG_CHAIN_LEN, 3'd0);
    write_register(REG_DATA_LENGTH, 3'd7);
    send_command(make_command(OP_WRITE, 8'h04, 8'hC3, 48'hDEADBEEFCAFE), 0);
    wait_drained();

    // Writes to spare indexes must leave both registers untouched.
    write_register(REG_SPARE_2, 3'd7);
    write_register(REG_SPARE_3, 3'd0);
    send_command(make_command(OP_WRITE, 8'h06, 8'h5A, 48'h112233445566), 0);
    wait_drained();

    write_register(REG_CHAIN_LEN, 3'd3);
    write_register(REG_DATA_LENGTH, 3'd1);
    send_command(make_command(OP_WRITE, 8'h07, 8'h00, 48'h0000000000FF), 0);
    send_command(make_command(OP_WRITE, 8'h00, 8'hFF, 48'hFFFFFFFFFF00), 0);
    wait_drained();

    // Random phases, one config setting each.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_register(REG_CHAIN_LEN, phase_devs[p]);
      write_register(REG_DATA_LENGTH, phase_len[p]);
      tx_idle   = (p != 2);
      rx_stalls = (p != 2);
      if (p == 4) begin
        // Long receiver hold-off while the sender keeps offering.
        tx_idle = 1'b0;
        @(posedge clk);
        rx_hold_req = 1'b1;
        @(negedge clk);
      end
      send_random(PHASE_ITEMS);
      wait_drained();
    end

    repeat (END_CYCLES) @(negedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d expected frame bytes never arrived", $time, sb.pending());
      sb.fail_count++;
    end
    if (sb.fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/pcfb_pkg.sv
hw/rtl/pcfb_if.sv
hw/rtl/pcfb_crc.sv
hw/rtl/pec15_command_frame_builder.sv
verif/tb_top.sv
